FILE: rtl/sd_spi_command_engine_core_macros.svh
// ----------------------------------------------------------------------------
// SD SPI command engine assertion macros
// Concurrent checks sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SD_SPI_COMMAND_ENGINE_CORE_MACROS_SVH
`define SD_SPI_COMMAND_ENGINE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// General property check
`define SDSPI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Signal must stay stable in the cycle after a condition
`define SDSPI_ASSERT_HOLD(label, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);
`else
`define SDSPI_ASSERT(label, prop, msg)
`define SDSPI_ASSERT_HOLD(label, cond, sig, msg)
`endif

`endif

FILE: rtl/sdspi_pkg.sv
// ----------------------------------------------------------------------------
// SD SPI command engine package
// Phase codes, frame constants, item types and the CRC7 byte update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdspi_pkg;

    // Phase codes of the command sequencer
    localparam logic [3:0] PH_IDLE_OFF    = 4'd0;
    localparam logic [3:0] PH_IDLE_ON     = 4'd1;
    localparam logic [3:0] PH_SEND        = 4'd2;
    localparam logic [3:0] PH_POLL        = 4'd3;
    localparam logic [3:0] PH_TRAIL       = 4'd4;
    localparam logic [3:0] PH_DESEL_RETRY = 4'd5;
    localparam logic [3:0] PH_DESEL_FINAL = 4'd6;

    // Item action codes
    localparam logic ACT_ISSUE = 1'b0;
    localparam logic ACT_RX    = 1'b1;

    // Configuration register indexes
    localparam logic CFG_RETRY_LIMIT = 1'b0;
    localparam logic CFG_POLL_LIMIT  = 1'b1;

    localparam logic [3:0] RETRY_LIMIT_RST = 4'd3;
    localparam logic [7:0] POLL_LIMIT_RST  = 8'd16;

    localparam logic [1:0] CMD_START_BITS = 2'b01;
    localparam logic [6:0] CRC7_POLY      = 7'h09;
    localparam logic [7:0] IDLE_BYTE      = 8'hff;
    localparam int         R1_CRC_BIT     = 3;
    localparam int         R1_BUSY_BIT    = 7;

    typedef struct packed {
        logic        action;
        logic [5:0]  cmd_index;
        logic [31:0] argument;
        logic        deselect_after;
        logic        long_response;
        logic [7:0]  rx_byte;
    } sdspi_req_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        card_selected;
        logic        done_res;
        logic [7:0]  r1_status;
        logic [31:0] trailing_word;
        logic        no_response;
        logic        retries_exhausted;
    } sdspi_rsp_t;

    // CRC7 update over one byte, MSB first
    function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] data);
        logic [6:0] c;
        logic       fb;
        c = crc_in;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[6] ^ data[i];
            c  = {c[5:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC7_POLY;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sdspi_req_if.sv
// ----------------------------------------------------------------------------
// SD SPI command engine request channel
// Valid/ready channel carrying issue commands and received bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sdspi_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic        deselect_after;
    logic        long_response;
    logic [7:0]  rx_byte;

    modport source (
        output valid, action, cmd_index, argument, deselect_after, long_response, rx_byte,
        input  ready
    );
    modport sink (
        input  valid, action, cmd_index, argument, deselect_after, long_response, rx_byte,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/sdspi_rsp_if.sv
// ----------------------------------------------------------------------------
// SD SPI command engine result channel
// Valid/ready channel carrying the next byte to send and command status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sdspi_rsp_if;
    logic        valid;
    logic        ready;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        card_selected;
    logic        done_res;
    logic [7:0]  r1_status;
    logic [31:0] trailing_word;
    logic        no_response;
    logic        retries_exhausted;

    modport source (
        output valid, tx_valid, tx_byte, card_selected, done_res, r1_status, trailing_word,
               no_response, retries_exhausted,
        input  ready
    );
    modport sink (
        input  valid, tx_valid, tx_byte, card_selected, done_res, r1_status, trailing_word,
               no_response, retries_exhausted,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/sdspi_in_stage.sv
// ----------------------------------------------------------------------------
// SD SPI command engine input register
// Captures one request transfer and holds it until the engine takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sd_spi_command_engine_core_macros.svh"

module sdspi_in_stage
    import sdspi_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    sdspi_req_if.sink   req,
    input  wire logic   advance,
    output logic        item_valid,
    output sdspi_req_t  item
);

    logic       valid_reg;
    sdspi_req_t item_reg;
    logic       load;

    // Accept while empty or while the held item moves on
    assign req.ready = !valid_reg || advance;
    assign load      = req.valid && req.ready;

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Capture payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.action         <= req.action;
            item_reg.cmd_index      <= req.cmd_index;
            item_reg.argument       <= req.argument;
            item_reg.deselect_after <= req.deselect_after;
            item_reg.long_response  <= req.long_response;
            item_reg.rx_byte        <= req.rx_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Held item must not change while the engine stalls
    `SDSPI_ASSERT_HOLD(a_in_hold, valid_reg && !advance, item_reg, "input item changed under stall")
    `SDSPI_ASSERT(a_in_keep, valid_reg && !advance |=> valid_reg, "input item dropped under stall")

endmodule

`default_nettype wire

FILE: rtl/sdspi_engine.sv
// ----------------------------------------------------------------------------
// SD SPI command engine sequencer
// Frame send, CRC7, R1 poll, trailing read and retry, one item per cycle unless a result is held.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sd_spi_command_engine_core_macros.svh"

module sdspi_engine
    import sdspi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        item_valid,
    input  wire sdspi_req_t  item,
    output logic             advance,
    sdspi_rsp_if.source      rsp
);

    // Configuration
    logic [3:0]  retry_limit_reg;
    logic [7:0]  poll_limit_reg;

    // Sequencer state
    logic [3:0]  phase_reg,   phase_next;
    logic [6:0]  crc_reg,     crc_next;
    logic [5:0]  cmd_reg,     cmd_next;
    logic [31:0] arg_reg,     arg_next;
    logic [2:0]  pos_reg,     pos_next;
    logic [7:0]  poll_reg,    poll_next;
    logic [3:0]  att_reg,     att_next;
    logic [7:0]  resp_reg,    resp_next;
    logic [31:0] trail_reg,   trail_next;
    logic        des_reg,     des_next;
    logic        lng_reg,     lng_next;

    // Result register
    logic        rsp_valid_reg;
    sdspi_rsp_t  rsp_reg, rsp_next;

    logic        process;
    logic [7:0]  resp_eff;
    logic [31:0] trail_eff;
    logic        crc_err;
    logic [3:0]  att_inc;
    logic        retry_go;
    logic [5:0]  seed_cmd;
    logic [7:0]  frame_byte;
    logic [2:0]  pos_inc;
    logic        do_finish;
    logic        do_start;

    assign advance = !rsp_valid_reg || rsp.ready;
    assign process = item_valid && advance;

    // Response values seen by the end of an attempt
    assign resp_eff  = (phase_reg == PH_POLL) ? item.rx_byte : resp_reg;
    assign trail_eff = (phase_reg == PH_TRAIL) ? {trail_reg[23:0], item.rx_byte} : trail_reg;
    assign crc_err   = des_reg && resp_eff[R1_CRC_BIT];
    assign att_inc   = att_reg + 4'd1;
    assign retry_go  = crc_err && (att_inc < retry_limit_reg);
    assign seed_cmd  = (item.action == ACT_ISSUE) ? item.cmd_index : cmd_reg;
    assign pos_inc   = pos_reg + 3'd1;

    // Select the frame byte at the current position
    always_comb
    begin
        case (pos_reg)
            3'd0:    frame_byte = {CMD_START_BITS, cmd_reg};
            3'd1:    frame_byte = arg_reg[31:24];
            3'd2:    frame_byte = arg_reg[23:16];
            3'd3:    frame_byte = arg_reg[15:8];
            3'd4:    frame_byte = arg_reg[7:0];
            default: frame_byte = {crc_reg, 1'b1};
        endcase
    end

    // Next state and result
    always_comb
    begin
        phase_next = phase_reg;
        crc_next   = crc_reg;
        cmd_next   = cmd_reg;
        arg_next   = arg_reg;
        pos_next   = pos_reg;
        poll_next  = poll_reg;
        att_next   = att_reg;
        resp_next  = resp_reg;
        trail_next = trail_reg;
        des_next   = des_reg;
        lng_next   = lng_reg;
        do_finish  = 1'b0;
        do_start   = 1'b0;
        rsp_next   = '0;
        rsp_next.card_selected = (phase_reg == PH_IDLE_ON);

        if (item.action == ACT_ISSUE)
        begin
            cmd_next = item.cmd_index;
            arg_next = item.argument;
            des_next = item.deselect_after;
            lng_next = item.long_response;
            att_next = 4'd0;
            do_start = 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_SEND:
                begin
                    rsp_next.tx_valid      = 1'b1;
                    rsp_next.card_selected = 1'b1;
                    if (pos_reg <= 3'd5)
                    begin
                        rsp_next.tx_byte = frame_byte;
                        pos_next         = pos_inc;
                        if (pos_reg != 3'd5)
                        begin
                            crc_next = crc7_byte(crc_reg, frame_byte);
                        end
                    end
                    else
                    begin
                        phase_next       = PH_POLL;
                        poll_next        = 8'd1;
                        rsp_next.tx_byte = IDLE_BYTE;
                    end
                end
                PH_POLL:
                begin
                    if (item.rx_byte[R1_BUSY_BIT] && (poll_reg < poll_limit_reg))
                    begin
                        poll_next              = poll_reg + 8'd1;
                        rsp_next.tx_valid      = 1'b1;
                        rsp_next.tx_byte       = IDLE_BYTE;
                        rsp_next.card_selected = 1'b1;
                    end
                    else
                    begin
                        resp_next = item.rx_byte;
                        if (lng_reg)
                        begin
                            phase_next             = PH_TRAIL;
                            pos_next               = 3'd0;
                            rsp_next.tx_valid      = 1'b1;
                            rsp_next.tx_byte       = IDLE_BYTE;
                            rsp_next.card_selected = 1'b1;
                        end
                        else
                        begin
                            do_finish = 1'b1;
                        end
                    end
                end
                PH_TRAIL:
                begin
                    trail_next = trail_eff;
                    pos_next   = pos_inc;
                    if (pos_inc < 3'd4)
                    begin
                        rsp_next.tx_valid      = 1'b1;
                        rsp_next.tx_byte       = IDLE_BYTE;
                        rsp_next.card_selected = 1'b1;
                    end
                    else
                    begin
                        do_finish = 1'b1;
                    end
                end
                PH_DESEL_RETRY:
                begin
                    do_start = 1'b1;
                end
                PH_DESEL_FINAL:
                begin
                    phase_next                 = PH_IDLE_OFF;
                    rsp_next.card_selected     = 1'b0;
                    rsp_next.done_res          = 1'b1;
                    rsp_next.r1_status         = resp_eff;
                    rsp_next.trailing_word     = lng_reg ? trail_eff : 32'd0;
                    rsp_next.no_response       = resp_eff[R1_BUSY_BIT];
                    rsp_next.retries_exhausted = crc_err;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        // End of an attempt: retry, deselect or report
        if (do_finish)
        begin
            if (crc_err)
            begin
                att_next = att_inc;
            end
            if (retry_go && lng_reg)
            begin
                phase_next             = PH_DESEL_RETRY;
                rsp_next.tx_valid      = 1'b1;
                rsp_next.tx_byte       = IDLE_BYTE;
                rsp_next.card_selected = 1'b0;
            end
            else if (retry_go)
            begin
                do_start = 1'b1;
            end
            else if (des_reg && lng_reg)
            begin
                phase_next             = PH_DESEL_FINAL;
                rsp_next.tx_valid      = 1'b1;
                rsp_next.tx_byte       = IDLE_BYTE;
                rsp_next.card_selected = 1'b0;
            end
            else
            begin
                phase_next                 = PH_IDLE_ON;
                rsp_next.card_selected     = 1'b1;
                rsp_next.done_res          = 1'b1;
                rsp_next.r1_status         = resp_eff;
                rsp_next.trailing_word     = lng_reg ? trail_eff : 32'd0;
                rsp_next.no_response       = resp_eff[R1_BUSY_BIT];
                rsp_next.retries_exhausted = crc_err;
            end
        end

        // Start a frame: send the command byte and seed the CRC
        if (do_start)
        begin
            phase_next             = PH_SEND;
            pos_next               = 3'd1;
            poll_next              = 8'd0;
            resp_next              = 8'd0;
            trail_next             = 32'd0;
            crc_next               = crc7_byte(7'd0, {CMD_START_BITS, seed_cmd});
            rsp_next.tx_valid      = 1'b1;
            rsp_next.tx_byte       = {CMD_START_BITS, seed_cmd};
            rsp_next.card_selected = 1'b1;
        end
    end

    // Write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg <= RETRY_LIMIT_RST;
            poll_limit_reg  <= POLL_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_RETRY_LIMIT)
            begin
                retry_limit_reg <= cfg_data[3:0];
            end
            else
            begin
                poll_limit_reg <= cfg_data;
            end
        end
    end

    // Advance sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE_OFF;
            crc_reg   <= '0;
            cmd_reg   <= '0;
            arg_reg   <= '0;
            pos_reg   <= '0;
            poll_reg  <= '0;
            att_reg   <= '0;
            resp_reg  <= '0;
            trail_reg <= '0;
            des_reg   <= 1'b0;
            lng_reg   <= 1'b0;
        end
        else if (process)
        begin
            phase_reg <= phase_next;
            crc_reg   <= crc_next;
            cmd_reg   <= cmd_next;
            arg_reg   <= arg_next;
            pos_reg   <= pos_next;
            poll_reg  <= poll_next;
            att_reg   <= att_next;
            resp_reg  <= resp_next;
            trail_reg <= trail_next;
            des_reg   <= des_next;
            lng_reg   <= lng_next;
        end
    end

    // Hold result until transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= process;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid             = rsp_valid_reg;
    assign rsp.tx_valid          = rsp_reg.tx_valid;
    assign rsp.tx_byte           = rsp_reg.tx_byte;
    assign rsp.card_selected     = rsp_reg.card_selected;
    assign rsp.done_res          = rsp_reg.done_res;
    assign rsp.r1_status         = rsp_reg.r1_status;
    assign rsp.trailing_word     = rsp_reg.trailing_word;
    assign rsp.no_response       = rsp_reg.no_response;
    assign rsp.retries_exhausted = rsp_reg.retries_exhausted;

    `SDSPI_ASSERT(a_take_result, process |=> rsp_valid_reg, "processed item gave no result")
    `SDSPI_ASSERT(a_done_no_tx, rsp_valid_reg && rsp_reg.done_res |-> !rsp_reg.tx_valid,
        "done result also asks for a byte")
    `SDSPI_ASSERT(a_desel_idle, rsp_valid_reg && rsp_reg.tx_valid && !rsp_reg.card_selected
        |-> rsp_reg.tx_byte == IDLE_BYTE, "deselected exchange not idle byte")
    `SDSPI_ASSERT(a_send_pos, phase_reg == PH_SEND |-> pos_reg >= 3'd1 && pos_reg <= 3'd6,
        "frame position out of range")

endmodule

`default_nettype wire

FILE: rtl/sd_spi_command_engine_core.sv
// ----------------------------------------------------------------------------
// SD SPI command engine
// A request transfer reaches its result through the input register, then the
// result register; one transfer per cycle is sustained while results are taken.
// While rsp.ready is low and a result is held, the result register holds, the
// input register takes a request transfer only if empty, and req.ready drops.
// Reset: rst_n clears to idle with the card deselected, retry limit 3,
// poll limit 16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sd_spi_command_engine_core
    import sdspi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,
    sdspi_req_if.sink        req,
    sdspi_rsp_if.source      rsp
);

    logic       item_valid;
    sdspi_req_t item;
    logic       advance;

    // Register the incoming transfer
    sdspi_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Run the command sequencer
    sdspi_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

FILE: verif/sdspi_exchange_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD SPI command engine exchange checker
// Watches the request, result and register ports, predicts the result of
// every request transfer from its own copy of the engine state, and
// compares each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module sdspi_exchange_checker
    import sdspi_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data,
    sdspi_req_if            req_mon,
    sdspi_rsp_if            rsp_mon,
    output int              fail_count,
    output int              pending,
    output int              exchanges_checked,
    output int              commands_done,
    output int              exhausted_seen,
    output int              silent_seen
);

    // Shadow copy of the engine configuration and state
    logic [3:0]  retry_lim;
    logic [7:0]  poll_lim;
    logic [3:0]  phase;
    logic [7:0]  frame_crc;
    logic [5:0]  held_cmd;
    logic [31:0] held_arg;
    logic [2:0]  byte_pos;
    logic [7:0]  poll_cnt;
    logic [3:0]  attempts;
    logic [7:0]  r1_byte;
    logic [31:0] trail;
    logic [1:0]  flags;    // bit 0 deselect after, bit 1 long response

    sdspi_rsp_t  expected_exchanges[$];
    sdspi_req_t  seen_req;
    sdspi_rsp_t  seen_rsp;
    sdspi_rsp_t  want;
    sdspi_rsp_t  fresh;

    // CRC7 over one byte, shifted one bit up so the data can be folded in whole
    function automatic logic [6:0] crc7_update(input logic [6:0] crc, input logic [7:0] d);
        logic [7:0] r;
        int         i;
        r = {crc, 1'b0} ^ d;
        for (i = 0; i < 8; i++)
        begin
            if (r[7])
                r = {r[6:0], 1'b0} ^ {CRC7_POLY, 1'b0};
            else
                r = {r[6:0], 1'b0};
        end
        return r[7:1];
    endfunction

    // Byte at a given position of the six-byte command frame
    function automatic logic [7:0] frame_octet(input logic [2:0] pos);
        if (pos == 3'd0)
            return {CMD_START_BITS, held_cmd};
        if (pos <= 3'd4)
            return 8'(held_arg >> (8 * (4 - int'(pos))));
        return frame_crc;
    endfunction

    function automatic sdspi_rsp_t tx_only(input logic [7:0] b, input logic sel);
        sdspi_rsp_t r;
        r               = '0;
        r.tx_valid      = 1'b1;
        r.tx_byte       = b;
        r.card_selected = sel;
        return r;
    endfunction

    function automatic sdspi_rsp_t done_status(input logic sel);
        sdspi_rsp_t r;
        r                   = '0;
        r.card_selected     = sel;
        r.done_res          = 1'b1;
        r.r1_status         = r1_byte;
        r.trailing_word     = flags[1] ? trail : 32'd0;
        r.no_response       = r1_byte[R1_BUSY_BIT];
        r.retries_exhausted = flags[0] & r1_byte[R1_CRC_BIT];
        return r;
    endfunction

    // Restart the frame from its first byte
    task automatic begin_frame(output sdspi_rsp_t r);
        phase    = PH_SEND;
        byte_pos = 3'd1;
        poll_cnt = 8'd0;
        r1_byte  = 8'd0;
        trail    = 32'd0;
        r        = tx_only(frame_octet(3'd0), 1'b1);
    endtask

    // Decide between retry, final deselect and done once R1 is in
    task automatic close_attempt(output sdspi_rsp_t r);
        logic retrying;
        retrying = 1'b0;
        if (flags[0] && r1_byte[R1_CRC_BIT])
        begin
            attempts = attempts + 4'd1;
            if (attempts < retry_lim)
            begin
                retrying = 1'b1;
                if (flags[1])
                begin
                    phase = PH_DESEL_RETRY;
                    r     = tx_only(IDLE_BYTE, 1'b0);
                end
                else
                begin
                    begin_frame(r);
                end
            end
        end
        if (!retrying)
        begin
            if (flags[0] && flags[1])
            begin
                phase = PH_DESEL_FINAL;
                r     = tx_only(IDLE_BYTE, 1'b0);
            end
            else
            begin
                phase = PH_IDLE_ON;
                r     = done_status(1'b1);
            end
        end
    endtask

    // Advance the shadow state by one request and produce its result
    task automatic predict_exchange(input sdspi_req_t it, output sdspi_rsp_t r);
        logic [6:0] c;
        int         k;
        if (it.action == ACT_ISSUE)
        begin
            held_cmd = it.cmd_index;
            held_arg = it.argument;
            flags    = {it.long_response, it.deselect_after};
            c = crc7_update(7'd0, {CMD_START_BITS, held_cmd});
            for (k = 1; k <= 4; k++)
                c = crc7_update(c, frame_octet(3'(k)));
            frame_crc = {c, 1'b1};
            attempts  = 4'd0;
            begin_frame(r);
        end
        else
        begin
            case (phase)
                PH_SEND:
                begin
                    if (byte_pos <= 3'd5)
                    begin
                        r        = tx_only(frame_octet(byte_pos), 1'b1);
                        byte_pos = byte_pos + 3'd1;
                    end
                    else
                    begin
                        phase    = PH_POLL;
                        poll_cnt = 8'd1;
                        r        = tx_only(IDLE_BYTE, 1'b1);
                    end
                end
                PH_POLL:
                begin
                    if (it.rx_byte[R1_BUSY_BIT] && poll_cnt < poll_lim)
                    begin
                        poll_cnt = poll_cnt + 8'd1;
                        r        = tx_only(IDLE_BYTE, 1'b1);
                    end
                    else
                    begin
                        r1_byte = it.rx_byte;
                        if (flags[1])
                        begin
                            phase    = PH_TRAIL;
                            byte_pos = 3'd0;
                            r        = tx_only(IDLE_BYTE, 1'b1);
                        end
                        else
                        begin
                            close_attempt(r);
                        end
                    end
                end
                PH_TRAIL:
                begin
                    trail    = {trail[23:0], it.rx_byte};
                    byte_pos = byte_pos + 3'd1;
                    if (byte_pos < 3'd4)
                        r = tx_only(IDLE_BYTE, 1'b1);
                    else
                        close_attempt(r);
                end
                PH_DESEL_RETRY:
                begin
                    begin_frame(r);
                end
                PH_DESEL_FINAL:
                begin
                    phase = PH_IDLE_OFF;
                    r     = done_status(1'b0);
                end
                default:
                begin
                    // Received byte while idle: ignore, report chip select only
                    r               = '0;
                    r.card_selected = (phase == PH_IDLE_ON);
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // Track register writes, result transfers and request transfers
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            retry_lim         = RETRY_LIMIT_RST;
            poll_lim          = POLL_LIMIT_RST;
            phase             = PH_IDLE_OFF;
            frame_crc         = 8'd0;
            held_cmd          = 6'd0;
            held_arg          = 32'd0;
            byte_pos          = 3'd0;
            poll_cnt          = 8'd0;
            attempts          = 4'd0;
            r1_byte           = 8'd0;
            trail             = 32'd0;
            flags             = 2'd0;
            expected_exchanges.delete();
            fail_count        = 0;
            pending           = 0;
            exchanges_checked = 0;
            commands_done     = 0;
            exhausted_seen    = 0;
            silent_seen       = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_RETRY_LIMIT)
                    retry_lim = cfg_data[3:0];
                else
                    poll_lim = cfg_data;
            end

            // Compare a result transfer with the oldest prediction
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                seen_rsp.tx_valid          = rsp_mon.tx_valid;
                seen_rsp.tx_byte           = rsp_mon.tx_byte;
                seen_rsp.card_selected     = rsp_mon.card_selected;
                seen_rsp.done_res          = rsp_mon.done_res;
                seen_rsp.r1_status         = rsp_mon.r1_status;
                seen_rsp.trailing_word     = rsp_mon.trailing_word;
                seen_rsp.no_response       = rsp_mon.no_response;
                seen_rsp.retries_exhausted = rsp_mon.retries_exhausted;
                if (expected_exchanges.size() == 0)
                begin
                    $error("result transfer with no prediction waiting");
                    fail_count++;
                end
                else
                begin
                    want = expected_exchanges.pop_front();
                    check_field("tx_valid", 32'(want.tx_valid), 32'(seen_rsp.tx_valid));
                    check_field("tx_byte", 32'(want.tx_byte), 32'(seen_rsp.tx_byte));
                    check_field("card_selected", 32'(want.card_selected),
                                32'(seen_rsp.card_selected));
                    check_field("done_res", 32'(want.done_res), 32'(seen_rsp.done_res));
                    check_field("r1_status", 32'(want.r1_status), 32'(seen_rsp.r1_status));
                    check_field("trailing_word", want.trailing_word, seen_rsp.trailing_word);
                    check_field("no_response", 32'(want.no_response),
                                32'(seen_rsp.no_response));
                    check_field("retries_exhausted", 32'(want.retries_exhausted),
                                32'(seen_rsp.retries_exhausted));
                    exchanges_checked++;
                    if (want.done_res)
                    begin
                        commands_done++;
                        if (want.retries_exhausted)
                            exhausted_seen++;
                        if (want.no_response)
                            silent_seen++;
                    end
                end
            end

            // Predict the result of a request transfer
            if (req_mon.valid && req_mon.ready)
            begin
                seen_req.action         = req_mon.action;
                seen_req.cmd_index      = req_mon.cmd_index;
                seen_req.argument       = req_mon.argument;
                seen_req.deselect_after = req_mon.deselect_after;
                seen_req.long_response  = req_mon.long_response;
                seen_req.rx_byte        = req_mon.rx_byte;
                predict_exchange(seen_req, fresh);
                expected_exchanges.push_back(fresh);
            end

            pending = expected_exchanges.size();
        end
    end

endmodule

FILE: verif/tb_sd_spi_command_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD SPI command engine testbench
// Plays the card side of SPI-mode command exchanges: issues commands and
// feeds back frame, poll, R1 and trailing bytes, with aborted sequences and
// stray bytes mixed in, over several retry and poll limit settings. The
// request side runs in bursts and the result side stalls on its own pattern.
// ----------------------------------------------------------------------------

module tb_sd_spi_command_engine_core;
    import sdspi_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int LIMIT_PHASES    = 8;
    localparam int ITEMS_PER_PHASE = 175;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PERIODIC,
        READY_STRETCH
    } ready_mode_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    sdspi_req_if req_ch();
    sdspi_rsp_if rsp_ch();

    int          fail_count;
    int          pending;
    int          exchanges_checked;
    int          commands_done;
    int          exhausted_seen;
    int          silent_seen;

    sdspi_req_t  card_items[$];
    sdspi_req_t  next_item;
    int          burst_left;
    int          gap_left;
    ready_mode_t rdy_mode;
    int          rdy_timer;
    logic [7:0]  beat;
    int          idle_cycles;
    logic [3:0]  cur_retry;
    logic [7:0]  cur_poll;
    int          settings_used;

    sd_spi_command_engine_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    sdspi_exchange_checker chk (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .req_mon           (req_ch),
        .rsp_mon           (rsp_ch),
        .fail_count        (fail_count),
        .pending           (pending),
        .exchanges_checked (exchanges_checked),
        .commands_done     (commands_done),
        .exhausted_seen    (exhausted_seen),
        .silent_seen       (silent_seen)
    );

    always #6 clk = ~clk;

    // Byte returned by the card; the latched fields are ignored, so randomize them
    function automatic sdspi_req_t rx_item(input logic [7:0] b);
        sdspi_req_t it;
        it.action         = ACT_RX;
        it.cmd_index      = 6'($urandom);
        it.argument       = $urandom;
        it.deselect_after = 1'($urandom);
        it.long_response  = 1'($urandom);
        it.rx_byte        = b;
        return it;
    endfunction

    function automatic sdspi_req_t issue_item(input logic [5:0] cmd, input logic [31:0] arg,
                                              input logic des, input logic lng);
        sdspi_req_t it;
        it.action         = ACT_ISSUE;
        it.cmd_index      = cmd;
        it.argument       = arg;
        it.deselect_after = des;
        it.long_response  = lng;
        it.rx_byte        = 8'($urandom);
        return it;
    endfunction

    // Queue one command exchange as a well-behaved card would answer it,
    // sometimes cut short; return the number of items that do work
    function automatic int plan_command();
        sdspi_req_t plan[$];
        int         eff_poll;
        int         eff_retry;
        int         fails;
        int         attempts;
        int         busy;
        int         a;
        int         k;
        int         cut;
        int         worked;
        logic       des;
        logic       lng;
        logic [5:0] cmd;
        logic [31:0] arg;
        logic [7:0] r1;

        eff_poll  = (cur_poll == 8'd0) ? 1 : int'(cur_poll);
        eff_retry = (cur_retry == 4'd0) ? 1 : int'(cur_retry);
        des = 1'($urandom);
        lng = 1'($urandom);
        cmd = 6'($urandom);
        arg = $urandom;
        case ($urandom_range(0, 9))
            0: arg = 32'h0000_0000;
            1: arg = 32'hffff_ffff;
            default: ;
        endcase
        if ($urandom_range(0, 9) == 0)
            cmd = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'd63;

        // Number of attempts whose R1 carries the CRC error bit
        fails = 0;
        if (des && $urandom_range(0, 2) == 0)
            fails = ($urandom_range(0, 2) == 0) ? eff_retry : $urandom_range(1, eff_retry);
        attempts = (fails >= eff_retry) ? eff_retry : fails + 1;

        plan.push_back(issue_item(cmd, arg, des, lng));
        for (a = 0; a < attempts; a++)
        begin
            if (a > 0 && lng)
                plan.push_back(rx_item(8'($urandom)));
            for (k = 0; k < 6; k++)
                plan.push_back(rx_item(8'($urandom)));
            if (eff_poll > 1 && $urandom_range(0, 15) == 0)
                busy = eff_poll - 1;
            else
                busy = $urandom_range(0, (eff_poll - 1 < 5) ? eff_poll - 1 : 5);
            for (k = 0; k < busy; k++)
                plan.push_back(rx_item(8'h80 | 8'($urandom_range(0, 127))));
            r1 = 8'($urandom);
            // Keep bit 7 set only on the last allowed poll
            if (busy != eff_poll - 1 || $urandom_range(0, 2) != 0)
                r1[R1_BUSY_BIT] = 1'b0;
            if (des)
                r1[R1_CRC_BIT] = (a < fails);
            plan.push_back(rx_item(r1));
            if (lng)
                for (k = 0; k < 4; k++)
                    plan.push_back(rx_item(8'($urandom)));
        end
        if (des && lng)
            plan.push_back(rx_item(8'($urandom)));

        // Drop the tail now and then so the next issue lands mid-command
        if ($urandom_range(0, 9) == 0)
        begin
            cut = $urandom_range(1, plan.size() - 1);
            while (plan.size() > cut)
                void'(plan.pop_back());
        end

        worked = plan.size();
        for (k = 0; k < plan.size(); k++)
            card_items.push_back(plan[k]);

        // Mix in stray traffic
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2))
                card_items.push_back(rx_item(8'($urandom)));
        if ($urandom_range(0, 11) == 0)
        begin
            card_items.push_back(issue_item(6'($urandom), $urandom, 1'($urandom),
                                            1'($urandom)));
            worked++;
        end
        return worked;
    endfunction

    // Hold until every queued item has gone and every result has come back
    task automatic settle();
        while (card_items.size() != 0 || req_ch.valid || pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limits(input logic [3:0] retry, input logic [7:0] polls);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RETRY_LIMIT;
        cfg_data  <= {4'd0, retry};
        @(posedge clk);
        cfg_index <= CFG_POLL_LIMIT;
        cfg_data  <= polls;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_retry = retry;
        cur_poll  = polls;
        settings_used++;
    endtask

    // Request side: bursts of transfers separated by random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left     <= gap_left - 1;
                    req_ch.valid <= 1'b0;
                end
                else if (card_items.size() != 0)
                begin
                    next_item = card_items.pop_front();
                    req_ch.valid          <= 1'b1;
                    req_ch.action         <= next_item.action;
                    req_ch.cmd_index      <= next_item.cmd_index;
                    req_ch.argument       <= next_item.argument;
                    req_ch.deselect_after <= next_item.deselect_after;
                    req_ch.long_response  <= next_item.long_response;
                    req_ch.rx_byte        <= next_item.rx_byte;
                    if (burst_left <= 1)
                    begin
                        burst_left <= ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 24);
                        gap_left   <= $urandom_range(0, 6);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result side: switch among stall patterns chosen at random
    always @(posedge clk)
    begin
        beat <= beat + 8'd1;
        if (rdy_timer == 0)
        begin
            rdy_mode  <= ready_mode_t'($urandom_range(0, 3));
            rdy_timer <= $urandom_range(40, 160);
        end
        else
        begin
            rdy_timer <= rdy_timer - 1;
        end
        case (rdy_mode)
            READY_ALWAYS:   rsp_ch.ready <= 1'b1;
            READY_RANDOM:   rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            READY_PERIODIC: rsp_ch.ready <= (beat[2:0] >= 3'd3);
            default:        rsp_ch.ready <= ($urandom_range(0, 15) == 0) ? ~rsp_ch.ready
                                                                         : rsp_ch.ready;
        endcase
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int ph;
        int k;
        int sent;

        clk                   = 1'b0;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = CFG_RETRY_LIMIT;
        cfg_data              = 8'd0;
        req_ch.valid          = 1'b0;
        req_ch.action         = ACT_RX;
        req_ch.cmd_index      = 6'd0;
        req_ch.argument       = 32'd0;
        req_ch.deselect_after = 1'b0;
        req_ch.long_response  = 1'b0;
        req_ch.rx_byte        = 8'd0;
        rsp_ch.ready          = 1'b1;
        burst_left            = 0;
        gap_left              = 0;
        rdy_mode              = READY_ALWAYS;
        rdy_timer             = 0;
        beat                  = 8'd0;
        idle_cycles           = 0;
        cur_retry             = RETRY_LIMIT_RST;
        cur_poll              = POLL_LIMIT_RST;
        settings_used         = 1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Byte while idle with the card deselected
        card_items.push_back(rx_item(8'h00));
        // Short command, R1 on the first poll; the card stays selected
        card_items.push_back(issue_item(6'd0, 32'h0000_0000, 1'b0, 1'b0));
        for (k = 0; k < 6; k++)
            card_items.push_back(rx_item(8'hff));
        card_items.push_back(rx_item(8'h00));
        // Byte while idle with the card still selected
        card_items.push_back(rx_item(8'hff));
        // Issue while busy: drop an extreme command for a long one with deselect
        card_items.push_back(issue_item(6'd63, 32'hffff_ffff, 1'b1, 1'b1));
        card_items.push_back(rx_item(8'hff));
        card_items.push_back(rx_item(8'h00));
        card_items.push_back(issue_item(6'd8, 32'h0000_01aa, 1'b1, 1'b1));
        for (k = 0; k < 6; k++)
            card_items.push_back(rx_item(8'hff));
        card_items.push_back(rx_item(8'h01));
        card_items.push_back(rx_item(8'h00));
        card_items.push_back(rx_item(8'h00));
        card_items.push_back(rx_item(8'h01));
        card_items.push_back(rx_item(8'haa));
        card_items.push_back(rx_item(8'hff));

        // Random exchanges under a series of limit settings, zero first and maximum third
        for (ph = 0; ph < LIMIT_PHASES; ph++)
        begin
            settle();
            case (ph)
                0: write_limits(4'd0, 8'd0);
                1: write_limits(4'd1, 8'd1);
                2: write_limits(4'd15, 8'd255);
                3: write_limits(4'd2, 8'd3);
                4: write_limits(4'd1, 8'd255);
                5: write_limits(4'd15, 8'd1);
                default: write_limits(4'($urandom_range(1, 15)), 8'($urandom_range(1, 12)));
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                @(negedge clk);
                if (card_items.size() < 16)
                    sent += plan_command();
            end
        end

        settle();
        $display("Checked %0d result transfers: %0d finished commands,",
                 exchanges_checked, commands_done);
        $display("%0d with no response, %0d out of retries, %0d limit settings incl. zero and max",
                 silent_seen, exhausted_seen, settings_used);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/sdspi_pkg.sv
rtl/sdspi_req_if.sv
rtl/sdspi_rsp_if.sv
rtl/sdspi_in_stage.sv
rtl/sdspi_engine.sv
rtl/sd_spi_command_engine_core.sv
verif/sdspi_exchange_checker.sv
verif/tb_sd_spi_command_engine_core.sv
